/* hw/rtl/lctd_pkg.sv */
// ----------------------------------------------------------------------------
// lctd_pkg
// Shared types, constants and character class functions of the login code
// text detector.
// ----------------------------------------------------------------------------
`default_nettype none

package lctd_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned DigitW = 4;
  localparam int unsigned LimitW = 16;

  localparam logic [DigitW-1:0] MinDigitsRst = DigitW'(5);
  localparam logic [DigitW-1:0] MaxDigitsRst = DigitW'(6);
  localparam logic [LimitW-1:0] ScanLimitRst = LimitW'(4096);
  localparam logic [DigitW-1:0] RunSat       = '1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MIN_DIGITS = 2'd0,
    REG_MAX_DIGITS = 2'd1,
    REG_SCAN_LIMIT = 2'd2
  } cfg_reg_e;

  // pending decision on a run that ended one unit earlier
  typedef enum logic [2:0] {
    PEND_NONE  = 3'b001,
    PEND_SEP   = 3'b010,
    PEND_SPACE = 3'b100
  } pend_e;

  typedef logic [UnitW-1:0] unit_t;

  localparam unit_t ChSpace  = 16'h0020;
  localparam unit_t ChDot    = 16'h002E;
  localparam unit_t ChUscore = 16'h005F;
  localparam unit_t ChPct    = 16'h0025;

  function automatic logic is_digit(unit_t v);
    is_digit = (v >= 16'h0030) && (v <= 16'h0039);
  endfunction

  function automatic logic is_letter(unit_t v);
    is_letter = ((v >= 16'h0061) && (v <= 16'h007A)) ||
                ((v >= 16'h0041) && (v <= 16'h005A));
  endfunction

  function automatic logic is_prefix(unit_t v);
    case (v)
      16'h0024, 16'hFF04, 16'h00A5, 16'hFFE5, 16'h20AC, 16'h00A3, 16'hFFE1,
      16'h20B9, 16'h20BD, 16'h20A9, 16'hFFE6, 16'h0E3F, 16'h20AB,
      16'h20B4: is_prefix = 1'b1;
      default:  is_prefix = 1'b0;
    endcase
  endfunction

  function automatic logic is_suffix(unit_t v);
    case (v)
      16'h5143, 16'h584A, 16'h5757, 16'h5713, 16'h5186, 16'h5E01, 16'h5E63,
      16'hC6D0, 16'h0024, 16'h00A5, 16'h20AC: is_suffix = 1'b1;
      default:                                is_suffix = 1'b0;
    endcase
  endfunction

  function automatic logic is_sep(unit_t v);
    case (v)
      16'h002E, 16'h002C, 16'h002D, 16'h002F, 16'h002B, 16'h003A,
      16'h0027: is_sep = 1'b1;
      default:  is_sep = 1'b0;
    endcase
  endfunction

  function automatic logic is_url_mark(unit_t v);
    case (v)
      16'h002F, 16'h005C, 16'h0040, 16'h003F, 16'h0026, 16'h003D, 16'h0025,
      16'h0023: is_url_mark = 1'b1;
      default:  is_url_mark = 1'b0;
    endcase
  endfunction

  function automatic logic is_break(unit_t v);
    is_break = ((v >= 16'h0009) && (v <= 16'h000D)) || (v == 16'h0020) ||
               (v == 16'h0085) || (v == 16'h00A0) || (v == 16'h1680) ||
               ((v >= 16'h2000) && (v <= 16'h200A)) || (v == 16'h2028) ||
               (v == 16'h2029) || (v == 16'h202F) || (v == 16'h205F) ||
               (v >= 16'h2E80);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/login_code_text_detector_top.sv */
// ----------------------------------------------------------------------------
// login_code_text_detector_top
// Scans a message one UTF-16 code unit per item and reports whether it
// holds a plausible one-time login code.
// ----------------------------------------------------------------------------
// Usage
//   input channel: in_valid_i / in_ready_o with code_unit_i and last_unit_i,
//   one code unit per item; last_unit_i marks the final unit of a message
//   output channel: out_valid_o / out_ready_i with code_found_o, exactly one
//   item per message, produced by the item carrying last_unit_i
//   config port: cfg_we_i writes cfg_wdata_i into register cfg_addr_i (0 min
//   digits, 1 max, 2 scan limit); user writes only while block is idle, unchecked
// Timing
//   an accepted item is registered, then judged against the per-message
//   state in the next cycle; a last item's result then goes into the result
//   register and onto out_valid_o, once that register is free to take it
//   one item per cycle sustained unless a last unit waits: every unit only
//   updates a handful of small registers through one short combinational step
// Reset
//   rst_ni clears the message state and restores 5 / 6 / 4096 config values
// Stall
//   a result waiting in the output register does not hold up ordinary units;
//   only a further last unit waits in the input register until the output
//   register is free, and in_ready_o drops for that time
// ----------------------------------------------------------------------------
`default_nettype none

module login_code_text_detector_top
  import lctd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration write port
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_addr_i,
  input  wire logic [LimitW-1:0] cfg_wdata_i,
  // input items
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [UnitW-1:0]  code_unit_i,
  input  wire logic              last_unit_i,
  // result items
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   code_found_o
);

  // configuration registers
  logic [DigitW-1:0] min_digits_q;
  logic [DigitW-1:0] max_digits_q;
  logic [LimitW-1:0] scan_limit_q;

  // input register
  logic  s1_valid_q;
  unit_t s1_unit_q;
  logic  s1_last_q;
  logic  s1_adv;

  // result register
  logic out_valid_q;
  logic code_found_q;

  // per-message state
  logic [LimitW-1:0] units_q, units_d;
  logic [DigitW-1:0] run_q, run_d;
  unit_t             prev_q, prev_d;
  logic              prev_vld_q, prev_vld_d;
  unit_t             lnb_q, lnb_d;          // last unit that is not a space
  logic              lnb_vld_q, lnb_vld_d;
  logic              ubp_digit_q, ubp_digit_d; // unit before previous is digit
  logic              left_rej_q, left_rej_d;   // run rejected by its left context
  logic              url_q, url_d;
  logic              cand_q, cand_d;
  pend_e             pend_q, pend_d;
  logic              code_q, code_d;

  // character classes of the current unit
  logic u_digit, u_letter, u_uscore, u_space, u_pct;
  logic u_suffix, u_sep, u_break, u_url;
  logic prev_digit, prev_dot, left_rej_now;
  logic do_scan, do_fin;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_digits_q <= MinDigitsRst;
      max_digits_q <= MaxDigitsRst;
      scan_limit_q <= ScanLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_MIN_DIGITS: min_digits_q <= cfg_wdata_i[DigitW-1:0];
        REG_MAX_DIGITS: max_digits_q <= cfg_wdata_i[DigitW-1:0];
        REG_SCAN_LIMIT: scan_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake: only a last unit can be held back by a full result register
  // --------------------------------------------------------------------------
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_unit_q <= code_unit_i;
      s1_last_q <= last_unit_i;
    end
  end

  // --------------------------------------------------------------------------
  // classification of the registered unit and of the stored context
  // --------------------------------------------------------------------------
  assign u_digit  = is_digit(s1_unit_q);
  assign u_letter = is_letter(s1_unit_q);
  assign u_uscore = (s1_unit_q == ChUscore);
  assign u_space  = (s1_unit_q == ChSpace);
  assign u_pct    = (s1_unit_q == ChPct);
  assign u_suffix = is_suffix(s1_unit_q);
  assign u_sep    = is_sep(s1_unit_q);
  assign u_break  = is_break(s1_unit_q);
  assign u_url    = is_url_mark(s1_unit_q);

  assign prev_digit = prev_vld_q && is_digit(prev_q);
  assign prev_dot   = prev_vld_q && (prev_q == ChDot);

  // left context of a run starting now: glued letter, currency prefix,
  // separator between digit groups, or space-separated digit group
  assign left_rej_now = (prev_vld_q && (is_letter(prev_q) || prev_q == ChUscore)) ||
                        (lnb_vld_q && is_prefix(lnb_q)) ||
                        (prev_vld_q && is_sep(prev_q) && ubp_digit_q) ||
                        (prev_vld_q && prev_q == ChSpace &&
                         lnb_vld_q && is_digit(lnb_q));

  assign do_scan = (units_q < scan_limit_q);

  // --------------------------------------------------------------------------
  // one unit: settle a pending decision, extend or judge the run, track the
  // token, then close the message at the scan limit or on the last unit
  // --------------------------------------------------------------------------
  always_comb begin
    units_d     = units_q;
    run_d       = run_q;
    prev_d      = prev_q;
    prev_vld_d  = prev_vld_q;
    lnb_d       = lnb_q;
    lnb_vld_d   = lnb_vld_q;
    ubp_digit_d = ubp_digit_q;
    left_rej_d  = left_rej_q;
    url_d       = url_q;
    cand_d      = cand_q;
    pend_d      = pend_q;
    code_d      = code_q;
    do_fin      = 1'b0;

    if (do_scan) begin
      // decision left open by the previous unit
      case (pend_q)
        PEND_SEP: begin
          pend_d = PEND_NONE;
          if (!u_digit) cand_d = 1'b1;
        end
        PEND_SPACE: begin
          if (!u_space) begin
            pend_d = PEND_NONE;
            if (!(u_suffix || u_pct || u_digit)) code_d = 1'b1;
          end
        end
        default: ;
      endcase

      if (u_digit) begin
        if (run_q == '0) begin
          left_rej_d = left_rej_now;
          run_d      = DigitW'(1);
        end else if (run_q != RunSat) begin
          run_d = run_q + DigitW'(1);
        end
      end else begin
        if (run_q != '0) begin
          // judge the finished run against the unit right after it
          if ((run_q >= min_digits_q) && (run_q <= max_digits_q) && !left_rej_q) begin
            if (u_letter || u_uscore) begin
            end else if (u_space) begin
              if (!url_q) pend_d = PEND_SPACE;
            end else if (u_suffix || u_pct) begin
            end else if (u_sep) begin
              pend_d = PEND_SEP;
            end else if (u_break) begin
              if (!url_q) code_d = 1'b1;
            end else begin
              cand_d = 1'b1;
            end
          end
          run_d = '0;
        end
        if (u_break) begin
          if (cand_d && !url_q) code_d = 1'b1;
          cand_d = 1'b0;
          url_d  = 1'b0;
        end else if (u_url || (prev_dot && u_letter)) begin
          url_d = 1'b1;
        end
      end

      ubp_digit_d = prev_digit;
      prev_d      = s1_unit_q;
      prev_vld_d  = 1'b1;
      if (!u_space) begin
        lnb_d     = s1_unit_q;
        lnb_vld_d = 1'b1;
      end
      units_d = units_q + LimitW'(1);
    end

    do_fin = (units_d >= scan_limit_q) || s1_last_q;

    if (do_fin) begin
      case (pend_d)
        PEND_SEP:   cand_d = 1'b1;
        PEND_SPACE: code_d = 1'b1;
        default: ;
      endcase
      pend_d = PEND_NONE;
      if (run_d != '0) begin
        // run reaching the end of the text
        if ((run_d >= min_digits_q) && (run_d <= max_digits_q) &&
            !left_rej_d && !url_d) code_d = 1'b1;
        run_d = '0;
      end
      if (cand_d && !url_d) code_d = 1'b1;
      cand_d = 1'b0;
      url_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      units_q     <= '0;
      run_q       <= '0;
      prev_q      <= '0;
      prev_vld_q  <= 1'b0;
      lnb_q       <= '0;
      lnb_vld_q   <= 1'b0;
      ubp_digit_q <= 1'b0;
      left_rej_q  <= 1'b0;
      url_q       <= 1'b0;
      cand_q      <= 1'b0;
      pend_q      <= PEND_NONE;
      code_q      <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        // message done: start the next one from scratch
        units_q     <= '0;
        run_q       <= '0;
        prev_q      <= '0;
        prev_vld_q  <= 1'b0;
        lnb_q       <= '0;
        lnb_vld_q   <= 1'b0;
        ubp_digit_q <= 1'b0;
        left_rej_q  <= 1'b0;
        url_q       <= 1'b0;
        cand_q      <= 1'b0;
        pend_q      <= PEND_NONE;
        code_q      <= 1'b0;
      end else begin
        units_q     <= units_d;
        run_q       <= run_d;
        prev_q      <= prev_d;
        prev_vld_q  <= prev_vld_d;
        lnb_q       <= lnb_d;
        lnb_vld_q   <= lnb_vld_d;
        ubp_digit_q <= ubp_digit_d;
        left_rej_q  <= left_rej_d;
        url_q       <= url_d;
        cand_q      <= cand_d;
        pend_q      <= pend_d;
        code_q      <= code_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !out_ready_i) || (s1_adv && s1_last_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      code_found_q <= code_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_found_o = code_found_q;

endmodule

`default_nettype wire

/* hw/rtl/lctd_checker.sv */
// ----------------------------------------------------------------------------
// lctd_checker
// Port-level checks of the login code text detector over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lctd_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic last_unit_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic code_found_o
);

  logic last_acc;
  assign last_acc = in_valid_i && in_ready_o && last_unit_i;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_found_o))
    else $error("result changed while stalled");

  // every accepted last item is followed by a valid result on the output
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |=> ##1 out_valid_o)
    else $error("no result after last item");

  // a fresh result only follows a last item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(last_acc, 2))
    else $error("result without last item");

  // input back-pressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

endmodule

bind login_code_text_detector_top lctd_checker u_lctd_checker (.*);

`default_nettype wire
